/* hw/rtl/fed_pkg.sv */
`default_nettype none
package fed_pkg;

  localparam int DEF_MAX_DELAY   = 16384;
  localparam int DEF_SAMPLE_BITS = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DLEN_W     = 15;
  localparam int COEF_W     = 17;
  localparam int FRAC_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH  = 3'd0,
    CFG_FEEDBACK_GAIN = 3'd1,
    CFG_WET_MIX       = 3'd2,
    CFG_OUTPUT_GAIN   = 3'd3,
    CFG_BYPASS_ON     = 3'd4
  } cfg_idx_t;

  localparam logic [COEF_W-1:0] Q16_ONE      = 17'd65536;
  localparam logic [DLEN_W-1:0] DLEN_RST     = 15'd9600;
  localparam logic [COEF_W-1:0] FB_GAIN_RST  = 17'd22938;
  localparam logic [COEF_W-1:0] WET_MIX_RST  = 17'd32768;
  localparam logic [COEF_W-1:0] OUT_GAIN_RST = 17'd65536;
  localparam logic              BYPASS_RST   = 1'b1;

  // one step of the per-item sequence
  typedef struct packed {
    logic ld;
    logic fb;
    logic dly;
    logic mw;
    logic mix;
    logic gain;
    logic res;
  } cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/fed_ram.sv */
`default_nettype none
module fed_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* hw/rtl/fed_chan.sv */
`default_nettype none
module fed_chan
  import fed_pkg::*;
#(
  parameter int MAX_DELAY   = DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                         clk,
  input  wire cmd_t                         cmd,
  input  wire logic                         rd_en,
  input  wire logic                         byp,
  input  wire logic                         hit,
  input  wire logic [COEF_W-1:0]            fb_gain,
  input  wire logic [COEF_W-1:0]            wet,
  input  wire logic [COEF_W-1:0]            dry_share,
  input  wire logic [COEF_W-1:0]            gain,
  input  wire logic [$clog2(MAX_DELAY)-1:0] raddr,
  input  wire logic [$clog2(MAX_DELAY)-1:0] waddr,
  input  wire logic [SAMPLE_BITS-1:0]       dry_in,
  output logic      [SAMPLE_BITS-1:0]       out
);

  localparam int SB = SAMPLE_BITS;
  localparam int DW = SB + 1;
  localparam int MW = COEF_W + 1;
  localparam int PW = DW + MW;
  localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(64'sd1);

  function automatic logic [SB-1:0] sat(input logic signed [PW-1:0] v);
    logic [SB-1:0] r;
    if (v > SMAX) begin
      r = SMAX[SB-1:0];
    end else if (v < SMIN) begin
      r = SMIN[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  logic [SB-1:0]        rdata;
  logic signed [SB-1:0] rd;
  logic signed [SB-1:0] dry_r;
  logic signed [DW-1:0] d_r;
  logic signed [DW-1:0] m_r;
  logic signed [PW-1:0] p_r;
  logic signed [PW-1:0] acc_r;
  logic [SB-1:0]        out_r;
  logic signed [DW-1:0] ma;
  logic signed [MW-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd_in;
  logic signed [PW-1:0] rnd_v;
  logic signed [PW-1:0] wsum;
  logic [SB-1:0]        wdata;

  fed_ram #(
    .W     (SB),
    .DEPTH (MAX_DELAY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.mw),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries past the fill count were never written and read as zero
  assign rd = hit ? signed'(rdata) : '0;

  always_comb begin
    ma = d_r;
    mb = signed'({1'b0, wet});
    if (cmd.fb) begin
      ma = DW'(rd);
      mb = signed'({1'b0, fb_gain});
    end else if (cmd.dly) begin
      ma = DW'(dry_r);
      mb = signed'({1'b0, dry_share});
    end else if (cmd.gain) begin
      ma = m_r;
      mb = signed'({1'b0, gain});
    end
  end

  assign prod   = ma * mb;
  assign rnd_in = cmd.mix ? (acc_r + p_r) : p_r;
  assign rnd_v  = (rnd_in + HALF) >>> FRAC_W;
  assign wsum   = PW'(dry_r) + PW'(d_r);
  assign wdata  = sat(wsum);

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      dry_r <= signed'(dry_in);
    end
    if (cmd.fb || cmd.dly || cmd.mw || cmd.gain) begin
      p_r <= prod;
    end
    if (cmd.dly) begin
      d_r <= rnd_v[DW-1:0];
    end
    if (cmd.mw) begin
      acc_r <= p_r;
    end
    if (cmd.mix) begin
      m_r <= rnd_v[DW-1:0];
    end
    if (cmd.res) begin
      out_r <= byp ? dry_r : sat(rnd_v);
    end
  end

  assign out = out_r;

endmodule
`default_nettype wire

/* hw/rtl/fed_dp.sv */
`default_nettype none
module fed_dp
  import fed_pkg::*;
#(
  parameter int MAX_DELAY   = DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output logic                        bypass,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [SAMPLE_BITS-1:0] left_in,
  input  wire logic [SAMPLE_BITS-1:0] right_in,
  output logic      [SAMPLE_BITS-1:0] left_out,
  output logic      [SAMPLE_BITS-1:0] right_out
);

  localparam int AW = $clog2(MAX_DELAY);
  localparam int FW = AW + 1;
  localparam int LW = (AW + 1 > DLEN_W + 1) ? AW + 1 : DLEN_W + 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_DELAY);

  logic [DLEN_W-1:0] dlen_r;
  logic [COEF_W-1:0] fb_r;
  logic [COEF_W-1:0] wet_r;
  logic [COEF_W-1:0] gain_r;
  logic              bypass_r;
  logic [COEF_W-1:0] coef_w;
  logic [COEF_W-1:0] dry_share;

  logic [AW-1:0] pos_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] pos_q_r;
  logic [LW-1:0] len_q_r;
  logic          hit_r;
  logic          byp_r;

  logic [LW-1:0] dlen_ext;
  logic [LW-1:0] len_c;
  logic [AW-1:0] pos_eff;
  logic [LW-1:0] pos_inc;
  logic          rd_en;

  assign coef_w = (cfg_wdata > Q16_ONE) ? Q16_ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlen_r   <= DLEN_RST;
      fb_r     <= FB_GAIN_RST;
      wet_r    <= WET_MIX_RST;
      gain_r   <= OUT_GAIN_RST;
      bypass_r <= BYPASS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DELAY_LENGTH:  dlen_r   <= cfg_wdata[DLEN_W-1:0];
        CFG_FEEDBACK_GAIN: fb_r     <= coef_w;
        CFG_WET_MIX:       wet_r    <= coef_w;
        CFG_OUTPUT_GAIN:   gain_r   <= coef_w;
        CFG_BYPASS_ON:     bypass_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign bypass    = bypass_r;
  assign dry_share = Q16_ONE - wet_r;

  // effective length and position
  assign dlen_ext = LW'(dlen_r);
  always_comb begin
    if (dlen_ext == '0) begin
      len_c = LW'(1);
    end else if (dlen_ext > LEN_MAX) begin
      len_c = LEN_MAX;
    end else begin
      len_c = dlen_ext;
    end
  end

  assign pos_eff = (LW'(pos_r) >= len_c) ? '0 : pos_r;
  assign pos_inc = LW'(pos_q_r) + LW'(1);
  assign rd_en   = cmd.ld && !bypass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      byp_r  <= 1'b0;
    end else begin
      if (cmd.ld) begin
        byp_r <= bypass_r;
      end
      if (cmd.mw) begin
        pos_r <= (pos_inc >= len_q_r) ? '0 : pos_inc[AW-1:0];
        if (FW'(pos_q_r) == fill_r) begin
          fill_r <= fill_r + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pos_q_r <= pos_eff;
      len_q_r <= len_c;
      hit_r   <= FW'(pos_eff) < fill_r;
    end
  end

  fed_chan #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk       (clk),
    .cmd       (cmd),
    .rd_en     (rd_en),
    .byp       (byp_r),
    .hit       (hit_r),
    .fb_gain   (fb_r),
    .wet       (wet_r),
    .dry_share (dry_share),
    .gain      (gain_r),
    .raddr     (pos_eff),
    .waddr     (pos_q_r),
    .dry_in    (left_in),
    .out       (left_out)
  );

  fed_chan #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_right (
    .clk       (clk),
    .cmd       (cmd),
    .rd_en     (rd_en),
    .byp       (byp_r),
    .hit       (hit_r),
    .fb_gain   (fb_r),
    .wet       (wet_r),
    .dry_share (dry_share),
    .gain      (gain_r),
    .raddr     (pos_eff),
    .waddr     (pos_q_r),
    .dry_in    (right_in),
    .out       (right_out)
  );

endmodule
`default_nettype wire

/* hw/rtl/fed_ctrl.sv */
`default_nettype none
module fed_ctrl
  import fed_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire logic bypass,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FB,
    S_DLY,
    S_MW,
    S_MIX,
    S_GAIN,
    S_RES
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd      = '0;
    cmd.ld   = (state_r == S_IDLE) && in_valid;
    cmd.fb   = (state_r == S_FB);
    cmd.dly  = (state_r == S_DLY);
    cmd.mw   = (state_r == S_MW);
    cmd.mix  = (state_r == S_MIX);
    cmd.gain = (state_r == S_GAIN);
    cmd.res  = (state_r == S_RES) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = bypass ? S_RES : S_FB;
        end
      end
      S_FB:   state_nxt = S_DLY;
      S_DLY:  state_nxt = S_MW;
      S_MW:   state_nxt = S_MIX;
      S_MIX:  state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_RES;
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* hw/rtl/feedback_echo_delay.sv */
`default_nettype none
// an item steps through FB, DLY, MW, MIX, GAIN and RES, or only RES with bypass;
// in_ready stays low until RES writes the result, and RES waits while out_valid
// holds an untaken one; one multiplier per channel does four products per item
// reset: synchronous, active low; registers take their defaults, position zero,
// rings read as zero through a fill count, so there is no clearing pass
module feedback_echo_delay
  import fed_pkg::*;
#(
  parameter int MAX_DELAY   = DEF_MAX_DELAY,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] in_left_in,
  input  wire logic [SAMPLE_BITS-1:0] in_right_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [SAMPLE_BITS-1:0] out_left_out,
  output logic      [SAMPLE_BITS-1:0] out_right_out,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cmd_t cmd;
  logic bypass;

  fed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bypass    (bypass),
    .cmd       (cmd)
  );

  fed_dp #(
    .MAX_DELAY   (MAX_DELAY),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .bypass    (bypass),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .left_in   (in_left_in),
    .right_in  (in_right_in),
    .left_out  (out_left_out),
    .right_out (out_right_out)
  );

`ifndef SYNTHESIS
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld, cmd.fb, cmd.dly, cmd.mw, cmd.mix, cmd.gain, cmd.res}))
    else $error("more than one sequencer step active");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready still high after an item was taken");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |-> (!out_valid || out_ready))
    else $error("result written over an item not yet taken");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res |=> out_valid)
    else $error("written result not presented");
`endif

endmodule
`default_nettype wire

/* bench/tb_top.sv */
module tb_top;
  import fed_pkg::*;

  localparam int SB          = DEF_SAMPLE_BITS;
  localparam int RING_DEPTH  = DEF_MAX_DELAY;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 5000;

  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam longint SAT_HI = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
  } echo_pair_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SB-1:0]         in_left_in = '0;
  logic [SB-1:0]         in_right_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SB-1:0]         out_left_out;
  logic [SB-1:0]         out_right_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DELAY_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // mirror of the block state
  int                left_ring [RING_DEPTH];
  int                right_ring [RING_DEPTH];
  int                ring_pos = 0;
  logic [DLEN_W-1:0] dlen_reg = DLEN_RST;
  logic [COEF_W-1:0] fb_reg = FB_GAIN_RST;
  logic [COEF_W-1:0] wet_reg = WET_MIX_RST;
  logic [COEF_W-1:0] gain_reg = OUT_GAIN_RST;
  logic              bypass_reg = BYPASS_RST;

  echo_pair_t predicted_pairs [$];
  int err_count = 0;
  int burst_left = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int quiet_cycles = 0;

  feedback_echo_delay u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip_sample(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint q16_unit(input logic [COEF_W-1:0] c);
    return (c > Q16_ONE) ? longint'(Q16_ONE) : longint'(c);
  endfunction

  // nearest, ties toward plus infinity
  function automatic longint round_q16(input longint v);
    return (v + 32768) >>> FRAC_W;
  endfunction

  function automatic longint echo_channel(input bit is_right, input int pos, input longint dry);
    longint stored;
    longint delayed;
    longint mixed;
    longint wet;
    wet = q16_unit(wet_reg);
    stored = is_right ? longint'(right_ring[pos]) : longint'(left_ring[pos]);
    delayed = round_q16(stored * q16_unit(fb_reg));
    if (is_right) right_ring[pos] = int'(clip_sample(dry + delayed));
    else left_ring[pos] = int'(clip_sample(dry + delayed));
    mixed = round_q16(dry * (longint'(Q16_ONE) - wet) + delayed * wet);
    return clip_sample(round_q16(mixed * q16_unit(gain_reg)));
  endfunction

  function automatic echo_pair_t echo_predict(input logic [SB-1:0] l, input logic [SB-1:0] r);
    echo_pair_t p;
    int len;
    int pos;
    longint out_l;
    longint out_r;
    if (bypass_reg) begin
      p.left = l;
      p.right = r;
      return p;
    end
    if (dlen_reg == 0) len = 1;
    else if (dlen_reg > RING_DEPTH) len = RING_DEPTH;
    else len = int'(dlen_reg);
    pos = (ring_pos >= len) ? 0 : ring_pos;
    out_l = echo_channel(1'b0, pos, longint'($signed(l)));
    out_r = echo_channel(1'b1, pos, longint'($signed(r)));
    p.left = out_l[SB-1:0];
    p.right = out_r[SB-1:0];
    pos++;
    if (pos >= len) pos = 0;
    ring_pos = pos;
    return p;
  endfunction

  function automatic logic [SB-1:0] rand_sample();
    logic [31:0] w;
    logic [SB-1:0] v;
    w = $urandom();
    case ($urandom_range(0, 7))
      0: v = S_MAX;
      1: v = S_MIN;
      2: v = SB'(w[5:0]) - SB'(32);
      default: v = w[SB-1:0];
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return Q16_ONE;
      2: return CFG_DATA_W'($urandom_range(65537, 131071));
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(RING_DEPTH + 1, 32767));
      2: return CFG_DATA_W'(RING_DEPTH);
      3: return CFG_DATA_W'($urandom_range(41, 2000));
      default: return CFG_DATA_W'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] want);
    err_count++;
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELAY_LENGTH:  dlen_reg = val[DLEN_W-1:0];
      CFG_FEEDBACK_GAIN: fb_reg = val[COEF_W-1:0];
      CFG_WET_MIX:       wet_reg = val[COEF_W-1:0];
      CFG_OUTPUT_GAIN:   gain_reg = val[COEF_W-1:0];
      CFG_BYPASS_ON:     bypass_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    predicted_pairs.push_back(echo_predict(l, r));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (predicted_pairs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_bypass_at_reset();
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('0, '1);
    send_pair(SB'(1), '0);
    wait_for_results();
  endtask

  task automatic test_reset_echo();
    write_cfg(CFG_BYPASS_ON, '0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    wait_for_results();
  endtask

  task automatic test_unity_feedback();
    write_cfg(CFG_DELAY_LENGTH, CFG_DATA_W'(2));
    write_cfg(CFG_FEEDBACK_GAIN, Q16_ONE);
    write_cfg(CFG_WET_MIX, Q16_ONE);
    write_cfg(CFG_OUTPUT_GAIN, Q16_ONE);
    repeat (5) send_pair(S_MAX, S_MIN);
    wait_for_results();
  endtask

  task automatic test_length_limits();
    write_cfg(CFG_DELAY_LENGTH, '0);
    write_cfg(CFG_FEEDBACK_GAIN, '1);
    write_cfg(CFG_WET_MIX, '1);
    write_cfg(CFG_OUTPUT_GAIN, '1);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(rand_sample(), rand_sample());
    wait_for_results();
    write_cfg(CFG_DELAY_LENGTH, CFG_DATA_W'(32767));
    send_pair(rand_sample(), rand_sample());
    send_pair(rand_sample(), rand_sample());
    wait_for_results();
  endtask

  task automatic test_length_shrink();
    write_cfg(CFG_DELAY_LENGTH, CFG_DATA_W'(8));
    write_cfg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(40000));
    write_cfg(CFG_WET_MIX, CFG_DATA_W'(20000));
    write_cfg(CFG_OUTPUT_GAIN, CFG_DATA_W'(50000));
    repeat (4) send_pair(rand_sample(), rand_sample());
    wait_for_results();
    write_cfg(CFG_DELAY_LENGTH, CFG_DATA_W'(3));
    repeat (2) send_pair(rand_sample(), rand_sample());
    wait_for_results();
  endtask

  task automatic test_bypass_hold();
    write_cfg(CFG_BYPASS_ON, CFG_DATA_W'(1));
    repeat (2) send_pair(rand_sample(), rand_sample());
    wait_for_results();
    write_cfg(CFG_BYPASS_ON, '0);
    repeat (2) send_pair(rand_sample(), rand_sample());
    wait_for_results();
  endtask

  task automatic test_output_stall();
    write_cfg(CFG_DELAY_LENGTH, CFG_DATA_W'(5));
    write_cfg(CFG_FEEDBACK_GAIN, CFG_DATA_W'(30000));
    write_cfg(CFG_WET_MIX, CFG_DATA_W'(30000));
    write_cfg(CFG_OUTPUT_GAIN, Q16_ONE);
    write_cfg(CFG_BYPASS_ON, '0);
    hold_token++;
    repeat (60) send_pair(rand_sample(), rand_sample());
    wait_for_results();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 7; phase++) begin
      write_cfg(CFG_DELAY_LENGTH, rand_length());
      write_cfg(CFG_FEEDBACK_GAIN, rand_coef());
      write_cfg(CFG_WET_MIX, rand_coef());
      write_cfg(CFG_OUTPUT_GAIN, rand_coef());
      write_cfg(CFG_BYPASS_ON, CFG_DATA_W'($urandom_range(0, 5) == 0));
      repeat (100) send_pair(rand_sample(), rand_sample());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_bypass_at_reset();
    test_reset_echo();
    test_unity_feedback();
    test_length_limits();
    test_length_shrink();
    test_bypass_hold();
    test_output_stall();
    test_random_settings();
    repeat (20) @(posedge clk);
    if (err_count == 0 && predicted_pairs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    echo_pair_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (predicted_pairs.size() == 0) begin
        report_mismatch("unexpected item", out_left_out, '0);
      end else begin
        want = predicted_pairs.pop_front();
        if (out_left_out !== want.left) report_mismatch("left_out", out_left_out, want.left);
        if (out_right_out !== want.right)
          report_mismatch("right_out", out_right_out, want.right);
      end
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_cycle % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
    rx_cycle++;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_we || !rst_n)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* feedback_echo_delay.f */
hw/rtl/fed_pkg.sv
hw/rtl/fed_ram.sv
hw/rtl/fed_chan.sv
hw/rtl/fed_dp.sv
hw/rtl/fed_ctrl.sv
hw/rtl/feedback_echo_delay.sv
bench/tb_top.sv
